FILE: sv/pip_pkg.sv
// Shared types and constants for the periodic interval projector.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package pip_pkg;

   // Number of shifts that are examined at most, starting from the lowest one.
   localparam int MAX_COPIES = 16;

   localparam int TICK_W  = 32;                         // signed tick values
   localparam int LEN_W   = 31;                         // loop length
   localparam int IDENT_W = 16;
   localparam int PITCH_W = 7;
   localparam int NUM_W   = 33;                         // divider numerator magnitude
   localparam int Q_W     = NUM_W + 2;                  // signed floor quotient
   localparam int POS_W   = 36 + $clog2(MAX_COPIES);    // running copy position
   localparam int ABS_W   = TICK_W + 1;                 // endpoint distance
   localparam int CNT_W   = $clog2(MAX_COPIES + 1);     // shift counter
   localparam int REQ_W   = 88;
   localparam int RSP_W   = 96;
   localparam int IDX_W   = 2;

   localparam logic signed [Q_W:0] MAX_SPAN = (Q_W + 1)'(MAX_COPIES);

   // Register indexes of the configuration port.
   localparam logic [IDX_W-1:0] REG_LOOP_LENGTH  = 2'd0;
   localparam logic [IDX_W-1:0] REG_WINDOW_START = 2'd1;
   localparam logic [IDX_W-1:0] REG_WINDOW_END   = 2'd2;
   localparam logic [IDX_W-1:0] REG_ORIGIN_TICK  = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIVA_GO,
      S_DIVA_RUN,
      S_FIXA,
      S_DIVB_GO,
      S_DIVB_RUN,
      S_FIXB,
      S_SPAN,
      S_DIST,
      S_PICK,
      S_DONE
   } pip_state_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] numer;
      logic [LEN_W-1:0] denom;
   } pip_div_req_type;

   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] quot;
      logic [LEN_W-1:0] rem;
   } pip_div_rsp_type;

   // True when a wide position still fits the signed 32-bit tick range.
   function automatic logic fits_tick(input logic signed [POS_W-1:0] v);
      fits_tick = (v == {{(POS_W - TICK_W){v[TICK_W-1]}}, v[TICK_W-1:0]});
   endfunction

endpackage

`default_nettype wire

FILE: sv/periodic_interval_projector.sv
// Top level of the periodic interval projector: sequencer, copy scan and ports.
// Depends on pip_pkg and instantiates the shared divider pip_div.
//
//   Channel | Direction | Handshake          | Contents
//   --------+-----------+--------------------+------------------------------------------
//   req_    | in        | tvalid / tready    | one note span, id and pitch per word
//   rsp_    | out       | tvalid / tready    | one projection result per word
//   csr_    | in        | write enable only  | loop length, window bounds, origin tick
//
// A word passes twice through the shared divider, then through the sequencing states
// and the two states of each shift examined (at most MAX_COPIES); with a zero loop
// length it goes straight to the result. A new word waits until the last is finished.
// The bit-serial divider and the two-step distance check per shift set the pace.
// Reset is synchronous, active high; it clears the sequencer, CSRs, counters and flags.
// While a word is in work req_tready is low. A finished result waits in the output
// register, and the next request word is taken while it waits.
`default_nettype none

module periodic_interval_projector (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // req_tdata from bit 0 up: span_start[31:0], span_end[31:0], note_ident[15:0],
   // note_pitch[6:0], one zero fill bit.
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [pip_pkg::REQ_W-1:0]   req_tdata,
   // rsp_tdata from bit 0 up: found, projected_start[31:0], projected_end[31:0],
   // result_ident[15:0], result_pitch[6:0], truncated, seven zero fill bits.
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [pip_pkg::RSP_W-1:0]        rsp_tdata,
   input  wire logic                        csr_we,
   input  wire logic [pip_pkg::IDX_W-1:0]   csr_index,
   input  wire logic [pip_pkg::TICK_W-1:0]  csr_wdata
);

   localparam int TW = pip_pkg::TICK_W;
   localparam int PW = pip_pkg::POS_W;
   localparam int QW = pip_pkg::Q_W;
   localparam int NW = pip_pkg::NUM_W;
   localparam int LW = pip_pkg::LEN_W;
   localparam int AW = pip_pkg::ABS_W;
   localparam int CW = pip_pkg::CNT_W;

   // Configuration registers.
   logic [LW-1:0]        loop_length_ff;
   logic signed [TW-1:0] window_start_ff, window_end_ff, origin_tick_ff;

   // Sequencer and the captured word.
   pip_pkg::pip_state_type               state_ff, state_in;
   logic signed [TW-1:0]                 span_start_ff, span_start_in;
   logic signed [TW-1:0]                 span_end_ff, span_end_in;
   logic [pip_pkg::IDENT_W-1:0]          ident_ff, ident_in;
   logic [pip_pkg::PITCH_W-1:0]          pitch_ff, pitch_in;

   // Floor division results and the scan state.
   logic                 neg_ff, neg_in;
   logic signed [QW-1:0] q_lo_ff, q_lo_in;
   logic signed [QW-1:0] q_hi_ff, q_hi_in;
   logic [LW-1:0]        r_lo_ff, r_lo_in;
   logic signed [PW-1:0] cs_ff, cs_in;
   logic signed [PW-1:0] ce_ff, ce_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic                 trunc_ff, trunc_in;
   logic [AW-1:0]        abs_a_ff, abs_a_in;
   logic [AW-1:0]        abs_b_ff, abs_b_in;
   logic                 hit_ff, hit_in;
   logic                 skip_ff, skip_in;
   logic                 found_ff, found_in;
   logic [AW-1:0]        best_d_ff, best_d_in;
   logic signed [TW-1:0] best_s_ff, best_s_in;
   logic signed [TW-1:0] best_e_ff, best_e_in;

   // Output register.
   logic                        rsp_tvalid_ff, rsp_tvalid_in;
   logic [pip_pkg::RSP_W-1:0]   rsp_tdata_ff, rsp_tdata_in;

   pip_pkg::pip_div_req_type div_req;
   pip_pkg::pip_div_rsp_type div_rsp;

   logic                 req_take;
   logic                 rsp_load;

   // Numerators of the two floor divisions, as sign and magnitude.
   logic signed [NW:0]   num_a_pos, num_a_neg, num_b_pos, num_b_neg;
   logic                 num_a_sign, num_b_sign;

   // Floor correction of the divider result.
   logic signed [QW-1:0] quot_ext, q_floor;
   logic                 rem_nz;

   // Span test and distance check.
   logic signed [QW:0]   k_span;
   logic signed [PW:0]   da, db, na, nb;
   logic [AW-1:0]        pick_d;
   logic                 pick_take, pick_stop;
   logic [CW-1:0]        idx_next;

   assign req_take = req_tvalid && req_tready;
   assign rsp_load = (state_ff == pip_pkg::S_DONE) && (!rsp_tvalid_ff || rsp_tready);

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         loop_length_ff  <= '0;
         window_start_ff <= '0;
         window_end_ff   <= '0;
         origin_tick_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            pip_pkg::REG_LOOP_LENGTH:  loop_length_ff  <= csr_wdata[LW-1:0];
            pip_pkg::REG_WINDOW_START: window_start_ff <= csr_wdata;
            pip_pkg::REG_WINDOW_END:   window_end_ff   <= csr_wdata;
            pip_pkg::REG_ORIGIN_TICK:  origin_tick_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The lowest shift comes from floor((window_start - span_end) / L) + 1, the highest
   // from floor((window_end - 1 - span_start) / L). Both go through the same divider.
   assign num_a_pos  = (NW + 1)'(window_start_ff) - (NW + 1)'(span_end_ff);
   assign num_a_neg  = (NW + 1)'(span_end_ff) - (NW + 1)'(window_start_ff);
   assign num_a_sign = num_a_pos[NW];
   assign num_b_pos  = (NW + 1)'(window_end_ff) - (NW + 1)'(span_start_ff)
                       - (NW + 1)'(1);
   assign num_b_neg  = (NW + 1)'(span_start_ff) + (NW + 1)'(1)
                       - (NW + 1)'(window_end_ff);
   assign num_b_sign = num_b_pos[NW];

   always_comb begin
      div_req.denom = loop_length_ff;
      div_req.start = 1'b0;
      div_req.numer = '0;
      case (state_ff)
         pip_pkg::S_DIVA_GO: begin
            div_req.start = 1'b1;
            div_req.numer = num_a_sign ? num_a_neg[NW-1:0] : num_a_pos[NW-1:0];
         end
         pip_pkg::S_DIVB_GO: begin
            div_req.start = 1'b1;
            div_req.numer = num_b_sign ? num_b_neg[NW-1:0] : num_b_pos[NW-1:0];
         end
         default: ;
      endcase
   end

   pip_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // A negative numerator with a remainder rounds one further down: -q - 1 is ~q.
   assign quot_ext = QW'(div_rsp.quot);
   assign rem_nz   = (div_rsp.rem != '0);
   always_comb begin
      if (!neg_ff) begin
         q_floor = quot_ext;
      end else if (rem_nz) begin
         q_floor = ~quot_ext;
      end else begin
         q_floor = -quot_ext;
      end
   end

   // Number of shifts in range is q_hi - q_lo.
   assign k_span = (QW + 1)'(q_hi_ff) - (QW + 1)'(q_lo_ff);

   // Distance of the origin to the current copy. The origin lies inside the copy
   // when it is at or after the start and before the exclusive end.
   assign da = (PW + 1)'(origin_tick_ff) - (PW + 1)'(cs_ff);
   assign db = (PW + 1)'(origin_tick_ff) - (PW + 1)'(ce_ff);
   assign na = (PW + 1)'(cs_ff) - (PW + 1)'(origin_tick_ff);
   assign nb = (PW + 1)'(ce_ff) - (PW + 1)'(origin_tick_ff);

   assign pick_d    = hit_ff ? '0 : ((abs_a_ff < abs_b_ff) ? abs_a_ff : abs_b_ff);
   assign pick_take = !skip_ff && (!found_ff || (pick_d < best_d_ff));
   assign idx_next  = idx_ff + CW'(1);
   assign pick_stop = (!skip_ff && (pick_d == '0)) || (idx_next == cnt_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pip_pkg::S_IDLE: begin
            if (req_take) begin
               state_in = (loop_length_ff == '0) ? pip_pkg::S_DONE : pip_pkg::S_DIVA_GO;
            end
         end
         pip_pkg::S_DIVA_GO:  state_in = pip_pkg::S_DIVA_RUN;
         pip_pkg::S_DIVA_RUN: if (div_rsp.done) state_in = pip_pkg::S_FIXA;
         pip_pkg::S_FIXA:     state_in = pip_pkg::S_DIVB_GO;
         pip_pkg::S_DIVB_GO:  state_in = pip_pkg::S_DIVB_RUN;
         pip_pkg::S_DIVB_RUN: if (div_rsp.done) state_in = pip_pkg::S_FIXB;
         pip_pkg::S_FIXB:     state_in = pip_pkg::S_SPAN;
         pip_pkg::S_SPAN: begin
            state_in = (k_span > (QW + 1)'(0)) ? pip_pkg::S_DIST : pip_pkg::S_DONE;
         end
         pip_pkg::S_DIST:     state_in = pip_pkg::S_PICK;
         pip_pkg::S_PICK: begin
            state_in = pick_stop ? pip_pkg::S_DONE : pip_pkg::S_DIST;
         end
         pip_pkg::S_DONE:     if (rsp_load) state_in = pip_pkg::S_IDLE;
         default:             state_in = pip_pkg::S_IDLE;
      endcase
   end

   // Handshake outputs.
   always_comb begin
      req_tready = 1'b0;
      case (state_ff)
         pip_pkg::S_IDLE: req_tready = 1'b1;
         default:         req_tready = 1'b0;
      endcase
   end

   // Datapath next values.
   always_comb begin
      span_start_in = span_start_ff;
      span_end_in   = span_end_ff;
      ident_in      = ident_ff;
      pitch_in      = pitch_ff;
      neg_in        = neg_ff;
      q_lo_in       = q_lo_ff;
      q_hi_in       = q_hi_ff;
      r_lo_in       = r_lo_ff;
      cs_in         = cs_ff;
      ce_in         = ce_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      trunc_in      = trunc_ff;
      abs_a_in      = abs_a_ff;
      abs_b_in      = abs_b_ff;
      hit_in        = hit_ff;
      skip_in       = skip_ff;
      found_in      = found_ff;
      best_d_in     = best_d_ff;
      best_s_in     = best_s_ff;
      best_e_in     = best_e_ff;
      case (state_ff)
         pip_pkg::S_IDLE: begin
            if (req_take) begin
               span_start_in = req_tdata[TW-1:0];
               span_end_in   = req_tdata[2*TW-1:TW];
               ident_in      = req_tdata[2*TW+pip_pkg::IDENT_W-1:2*TW];
               pitch_in      = req_tdata[2*TW+pip_pkg::IDENT_W+pip_pkg::PITCH_W-1:
                                         2*TW+pip_pkg::IDENT_W];
               found_in      = 1'b0;
               trunc_in      = 1'b0;
            end
         end
         pip_pkg::S_DIVA_GO: neg_in = num_a_sign;
         pip_pkg::S_FIXA: begin
            q_lo_in = q_floor;
            r_lo_in = (neg_ff && rem_nz) ? (loop_length_ff - div_rsp.rem) : div_rsp.rem;
         end
         pip_pkg::S_DIVB_GO: begin
            neg_in = num_b_sign;
            // End of the lowest copy: window_start - floor remainder + L.
            ce_in  = PW'(window_start_ff) + PW'(loop_length_ff) - PW'(r_lo_ff);
         end
         pip_pkg::S_DIVB_RUN: begin
            cs_in = ce_ff + PW'(span_start_ff) - PW'(span_end_ff);
         end
         pip_pkg::S_FIXB: q_hi_in = q_floor;
         pip_pkg::S_SPAN: begin
            idx_in = '0;
            if (k_span > pip_pkg::MAX_SPAN) begin
               trunc_in = 1'b1;
               cnt_in   = CW'(pip_pkg::MAX_COPIES);
            end else begin
               cnt_in   = k_span[CW-1:0];
            end
         end
         pip_pkg::S_DIST: begin
            hit_in   = !da[PW] && db[PW];
            skip_in  = !pip_pkg::fits_tick(cs_ff) || !pip_pkg::fits_tick(ce_ff);
            abs_a_in = da[PW] ? na[AW-1:0] : da[AW-1:0];
            abs_b_in = db[PW] ? nb[AW-1:0] : db[AW-1:0];
         end
         pip_pkg::S_PICK: begin
            if (pick_take) begin
               found_in  = 1'b1;
               best_d_in = pick_d;
               best_s_in = cs_ff[TW-1:0];
               best_e_in = ce_ff[TW-1:0];
            end
            cs_in  = cs_ff + PW'(loop_length_ff);
            ce_in  = ce_ff + PW'(loop_length_ff);
            idx_in = idx_next;
         end
         default: ;
      endcase
   end

   // Result word; the copy fields read zero when nothing was found.
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      if (rsp_load) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {7'd0, trunc_ff,
                          found_ff ? pitch_ff : pip_pkg::PITCH_W'(0),
                          found_ff ? ident_ff : pip_pkg::IDENT_W'(0),
                          found_ff ? best_e_ff : TW'(0),
                          found_ff ? best_s_ff : TW'(0),
                          found_ff};
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pip_pkg::S_IDLE;
         rsp_tvalid_ff <= 1'b0;
         found_ff      <= 1'b0;
         trunc_ff      <= 1'b0;
         cnt_ff        <= '0;
         idx_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         found_ff      <= found_in;
         trunc_ff      <= trunc_in;
         cnt_ff        <= cnt_in;
         idx_ff        <= idx_in;
      end
      span_start_ff <= span_start_in;
      span_end_ff   <= span_end_in;
      ident_ff      <= ident_in;
      pitch_ff      <= pitch_in;
      neg_ff        <= neg_in;
      q_lo_ff       <= q_lo_in;
      q_hi_ff       <= q_hi_in;
      r_lo_ff       <= r_lo_in;
      cs_ff         <= cs_in;
      ce_ff         <= ce_in;
      abs_a_ff      <= abs_a_in;
      abs_b_ff      <= abs_b_in;
      hit_ff        <= hit_in;
      skip_ff       <= skip_in;
      best_d_ff     <= best_d_in;
      best_s_ff     <= best_s_in;
      best_e_ff     <= best_e_in;
      rsp_tdata_ff  <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // A result without a copy carries zeros in every copy field.
   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !rsp_tdata_ff[0]) |-> (rsp_tdata_ff[87:1] == '0))
      else $error("not-found result carries nonzero copy fields");

   // The scan only runs with a shift index below a bounded count.
   a_scan_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pip_pkg::S_DIST || state_ff == pip_pkg::S_PICK)
      |-> (idx_ff < cnt_ff && cnt_ff <= CW'(pip_pkg::MAX_COPIES)))
      else $error("copy scan index out of bounds");

   // The divider only finishes while the sequencer waits for it.
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == pip_pkg::S_DIVA_RUN || state_ff == pip_pkg::S_DIVB_RUN))
      else $error("divider finished outside a wait state");

   // A copy that holds the origin ends the scan at once.
   a_hit_stops: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pip_pkg::S_PICK && !skip_ff && hit_ff) |=> (state_ff == pip_pkg::S_DONE))
      else $error("scan went on after a containing copy");

endmodule

`default_nettype wire

FILE: sv/pip_div.sv
// Restoring divider, one quotient bit per cycle, unsigned magnitudes only.
// Depends on pip_pkg for widths and the request and response structs.
`default_nettype none

module pip_div (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire pip_pkg::pip_div_req_type div_req,
   output pip_pkg::pip_div_rsp_type      div_rsp
);

   localparam int STEP_W = $clog2(pip_pkg::NUM_W + 1);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [STEP_W-1:0]           step_ff, step_in;
   logic [pip_pkg::NUM_W-1:0]   quot_ff, quot_in;
   logic [pip_pkg::LEN_W-1:0]   rem_ff, rem_in;
   logic [pip_pkg::LEN_W-1:0]   denom_ff, denom_in;

   logic [pip_pkg::LEN_W:0]     trial;
   logic [pip_pkg::LEN_W:0]     trial_sub;
   logic                        fits;

   assign trial     = {rem_ff, quot_ff[pip_pkg::NUM_W-1]};
   assign trial_sub = trial - {1'b0, denom_ff};
   assign fits      = (trial >= {1'b0, denom_ff});

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      denom_in = denom_ff;
      if (div_req.start) begin
         busy_in  = 1'b1;
         step_in  = STEP_W'(pip_pkg::NUM_W);
         quot_in  = div_req.numer;
         rem_in   = '0;
         denom_in = div_req.denom;
      end else if (busy_ff) begin
         quot_in = {quot_ff[pip_pkg::NUM_W-2:0], fits};
         rem_in  = fits ? trial_sub[pip_pkg::LEN_W-1:0] : trial[pip_pkg::LEN_W-1:0];
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      denom_ff <= denom_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;
   assign div_rsp.rem  = rem_ff;

endmodule

`default_nettype wire
